// ===== hw/rtl/mesh_router_queue_route_macros.svh =====
// Assertion macros for the mesh router queue.
// Included by the top level; no other dependencies.
`ifndef MESH_ROUTER_QUEUE_ROUTE_MACROS_SVH
`define MESH_ROUTER_QUEUE_ROUTE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MRQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrq_pkg.sv =====
// Shared types, constants and helpers of the mesh router queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned MaxMesh    = 64;

  localparam int unsigned CoordW    = 6;
  localparam int unsigned LenW      = 7;
  localparam int unsigned KindW     = 2;
  localparam int unsigned TagW      = 16;
  localparam int unsigned DelayW    = 32;
  localparam int unsigned CfgDelayW = 16;
  localparam int unsigned CountW    = 32;

  // Running sum of queuing delay; the gap seen by one entry stays below 2^QaccW.
  localparam int unsigned QaccW = CfgDelayW + CntW;

  // Command queue between front and back.
  localparam int unsigned CqDepth = 4;
  localparam int unsigned CqPtrW  = $clog2(CqDepth);
  localparam int unsigned CqCntW  = $clog2(CqDepth + 1);

  // Result queue at the output.
  localparam int unsigned OqDepth = 2;
  localparam int unsigned OqPtrW  = $clog2(OqDepth);
  localparam int unsigned OqCntW  = $clog2(OqDepth + 1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgMyX         = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMyY         = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMeshLen     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgQueuingDly  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRouteDly    = 3'd4;

  typedef enum logic [3:0] {
    ACT_QUEUED  = 4'd0,
    ACT_DROPPED = 4'd1,
    ACT_EMPTY   = 4'd2,
    ACT_LOCAL   = 4'd3,
    ACT_WEST    = 4'd4,
    ACT_EAST    = 4'd5,
    ACT_NORTH   = 4'd6,
    ACT_SOUTH   = 4'd7,
    ACT_MEMORY  = 4'd8,
    ACT_BADKIND = 4'd9
  } action_e;

  typedef struct packed {
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic              to_mem;
    logic              bcast;
    logic [KindW-1:0]  kind;
    logic [TagW-1:0]   tag;
  } msg_t;

  typedef struct packed {
    logic              dispatch;
    logic              prefer_vert;
    msg_t              msg;
    logic [DelayW-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [CoordW-1:0]    my_x;
    logic [CoordW-1:0]    my_y;
    logic [LenW-1:0]      mesh_len;
    logic [CfgDelayW-1:0] queuing_delay;
    logic [CfgDelayW-1:0] route_delay;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    msg_t              msg;
    logic [DelayW-1:0] delay;
    logic [CountW-1:0] count;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] fill;
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
  } back_stat_t;

  // Saturating add of two delays.
  function automatic logic [DelayW-1:0] sat_add(input logic [DelayW-1:0] a,
                                                input logic [DelayW-1:0] b);
    logic [DelayW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DelayW] ? {DelayW{1'b1}} : sum[DelayW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrq_front.sv =====
// Front end: takes items, adds the routing delay and packs commands.
// Depends on mrq_pkg; feeds mrq_cmdq.
`timescale 1ns / 1ps
`default_nettype none

module mrq_front (
  input  wire logic                          push_i,
  input  wire logic                          cmd_i,
  input  wire logic [mrq_pkg::CoordW-1:0]    dest_x_i,
  input  wire logic [mrq_pkg::CoordW-1:0]    dest_y_i,
  input  wire logic                          to_memory_i,
  input  wire logic                          is_broadcast_i,
  input  wire logic [mrq_pkg::KindW-1:0]     msg_kind_i,
  input  wire logic [mrq_pkg::TagW-1:0]      tag_in_i,
  input  wire logic [mrq_pkg::DelayW-1:0]    delay_in_i,
  input  wire logic                          prefer_vertical_i,
  input  wire logic [mrq_pkg::CfgDelayW-1:0] route_delay_i,
  input  wire logic                          cq_full_i,
  output logic                               full_o,
  output logic                               cq_push_o,
  output mrq_pkg::cmd_t                      cq_wdata_o
);
  import mrq_pkg::*;

  assign full_o    = cq_full_i;
  assign cq_push_o = push_i && !cq_full_i;

  always_comb begin
    cq_wdata_o             = '0;
    cq_wdata_o.dispatch    = cmd_i;
    cq_wdata_o.prefer_vert = prefer_vertical_i;
    // Only enqueues carry a message; a dispatch needs nothing but the bias bit.
    if (!cmd_i) begin
      cq_wdata_o.msg.dest_x = dest_x_i;
      cq_wdata_o.msg.dest_y = dest_y_i;
      cq_wdata_o.msg.to_mem = to_memory_i;
      cq_wdata_o.msg.bcast  = is_broadcast_i;
      cq_wdata_o.msg.kind   = msg_kind_i;
      cq_wdata_o.msg.tag    = tag_in_i;
      cq_wdata_o.delay      = sat_add(delay_in_i, DelayW'(route_delay_i));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrq_cmdq.sv =====
// Short command queue between front and back end.
// Depends on mrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrq_cmdq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mrq_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output mrq_pkg::cmd_t      rdata_o,
  output logic               empty_o
);
  import mrq_pkg::*;

  cmd_t              mem_q [CqDepth];
  logic [CqPtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CqCntW-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CqCntW'(CqDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == CqPtrW'(CqDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == CqPtrW'(CqDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrq_back.sv =====
// Back end: message store, queuing delay, route decision and result queue.
// Depends on mrq_pkg; fed by mrq_cmdq.
`timescale 1ns / 1ps
`default_nettype none

module mrq_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mrq_pkg::cfg_t   cfg_i,
  input  wire logic            cmd_valid_i,
  input  wire mrq_pkg::cmd_t   cmd_i,
  output logic                 cmd_pop_o,
  output mrq_pkg::result_t     res_o,
  output logic                 res_empty_o,
  input  wire logic            res_pop_i,
  output mrq_pkg::back_stat_t  stat_o
);
  import mrq_pkg::*;

  // Message store; each entry keeps its delay base and the queuing sum at entry.
  msg_t              msg_q  [QueueDepth];
  logic [DelayW-1:0] base_q [QueueDepth];
  logic [QaccW-1:0]  snap_q [QueueDepth];

  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [QaccW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] pkt_q, pkt_d;

  // Result queue.
  result_t           oq_q [OqDepth];
  logic [OqPtrW-1:0] oq_rd_q, oq_rd_d, oq_wr_q, oq_wr_d;
  logic [OqCntW-1:0] oq_cnt_q, oq_cnt_d;
  logic              oq_full, oq_pop;

  logic              go, store_wr;
  result_t           res_d;
  msg_t              hd_msg;
  logic [QaccW-1:0]  acc_new, wait_sum;
  logic [DelayW-1:0] hd_delay;
  action_e           route_act, mem_act;

  logic [LenW-1:0]   len;
  logic signed [8:0] sx, sy, sl, lmx, lmy, mx, my;

  assign oq_full     = (oq_cnt_q == OqCntW'(OqDepth));
  assign res_empty_o = (oq_cnt_q == '0);
  assign res_o       = oq_q[oq_rd_q];
  assign oq_pop      = res_pop_i && !res_empty_o;
  assign go          = cmd_valid_i && !oq_full;
  assign cmd_pop_o   = go;

  assign stat_o.fill = fill_q;
  assign stat_o.head = head_q;
  assign stat_o.tail = tail_q;

  // Every dispatch adds queuing delay to all waiting entries; track it as a sum.
  assign hd_msg   = msg_q[head_q];
  assign acc_new  = acc_q + QaccW'(cfg_i.queuing_delay);
  assign wait_sum = acc_new - snap_q[head_q];
  assign hd_delay = sat_add(base_q[head_q], DelayW'(wait_sum));

  // Memory-bound step: toward the nearest edge, or memory on a boundary tile.
  assign len = (cfg_i.mesh_len > LenW'(MaxMesh)) ? LenW'(MaxMesh) : cfg_i.mesh_len;
  assign sx  = $signed({3'b000, cfg_i.my_x});
  assign sy  = $signed({3'b000, cfg_i.my_y});
  assign sl  = $signed({2'b00, len});
  assign lmx = sl - sx;
  assign lmy = sl - sy;
  assign mx  = (sx < lmx) ? sx : lmx;
  assign my  = (sy < lmy) ? sy : lmy;

  always_comb begin
    if (sx == 9'sd0 || sy == 9'sd0 || sx >= sl - 9'sd1 || sy >= sl - 9'sd1) begin
      mem_act = ACT_MEMORY;
    end else if (mx < my) begin
      mem_act = (sx < lmx) ? ACT_WEST : ACT_EAST;
    end else begin
      mem_act = (sy < lmy) ? ACT_NORTH : ACT_SOUTH;
    end
  end

  always_comb begin
    if ((hd_msg.dest_x == cfg_i.my_x && hd_msg.dest_y == cfg_i.my_y) || hd_msg.bcast) begin
      route_act = hd_msg.kind[1] ? ACT_BADKIND : ACT_LOCAL;
    end else if (hd_msg.to_mem) begin
      route_act = mem_act;
    end else if (cmd_i.prefer_vert ? (hd_msg.dest_y != cfg_i.my_y)
                                   : (hd_msg.dest_x == cfg_i.my_x)) begin
      route_act = (hd_msg.dest_y > cfg_i.my_y) ? ACT_SOUTH : ACT_NORTH;
    end else begin
      route_act = (hd_msg.dest_x > cfg_i.my_x) ? ACT_EAST : ACT_WEST;
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    acc_d    = acc_q;
    pkt_d    = pkt_q;
    store_wr = 1'b0;
    res_d    = '0;
    res_d.action = ACT_QUEUED;
    if (!cmd_i.dispatch) begin
      if (fill_q == CntW'(QueueDepth)) begin
        res_d.action = ACT_DROPPED;
      end else begin
        store_wr = 1'b1;
        tail_d   = (tail_q == PtrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
        fill_d   = fill_q + 1'b1;
        pkt_d    = pkt_q + 1'b1;
      end
    end else if (fill_q == '0) begin
      res_d.action = ACT_EMPTY;
    end else begin
      acc_d        = acc_new;
      head_d       = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
      fill_d       = fill_q - 1'b1;
      res_d.action = route_act;
      res_d.msg    = hd_msg;
      res_d.delay  = hd_delay;
    end
    res_d.count = pkt_d;
  end

  always_comb begin
    oq_rd_d  = oq_rd_q;
    oq_wr_d  = oq_wr_q;
    oq_cnt_d = oq_cnt_q;
    if (go) begin
      oq_wr_d = (oq_wr_q == OqPtrW'(OqDepth - 1)) ? '0 : oq_wr_q + 1'b1;
    end
    if (oq_pop) begin
      oq_rd_d = (oq_rd_q == OqPtrW'(OqDepth - 1)) ? '0 : oq_rd_q + 1'b1;
    end
    if (go && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_pop && !go) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      acc_q    <= '0;
      pkt_q    <= '0;
      oq_rd_q  <= '0;
      oq_wr_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_rd_q  <= oq_rd_d;
      oq_wr_q  <= oq_wr_d;
      oq_cnt_q <= oq_cnt_d;
      if (go) begin
        head_q <= head_d;
        tail_q <= tail_d;
        fill_q <= fill_d;
        acc_q  <= acc_d;
        pkt_q  <= pkt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && store_wr) begin
      msg_q[tail_q]  <= cmd_i.msg;
      base_q[tail_q] <= cmd_i.delay;
      snap_q[tail_q] <= acc_q;
    end
    if (go) begin
      oq_q[oq_wr_q] <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_router_queue_route.sv =====
// Mesh router queue: an accepted item passes the command queue and then the result
// queue before its result word shows on the ports, when no older word waits ahead.
// Throughput is one item per cycle unless a full queue stalls it; front and back
// ends retire one word a cycle, with a 4-word command and a 2-word result queue.
// Reset (asynchronous, active low) empties both queues and the message store,
// clears the packet count and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_router_queue_route_macros.svh"

module mesh_router_queue_route (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mrq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mrq_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          cmd_i,
  input  wire logic [mrq_pkg::CoordW-1:0]    dest_x_i,
  input  wire logic [mrq_pkg::CoordW-1:0]    dest_y_i,
  input  wire logic                          to_memory_i,
  input  wire logic                          is_broadcast_i,
  input  wire logic [mrq_pkg::KindW-1:0]     msg_kind_i,
  input  wire logic [mrq_pkg::TagW-1:0]      tag_in_i,
  input  wire logic [mrq_pkg::DelayW-1:0]    delay_in_i,
  input  wire logic                          prefer_vertical_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [3:0]                         action_o,
  output logic [mrq_pkg::CoordW-1:0]         dest_x_out_o,
  output logic [mrq_pkg::CoordW-1:0]         dest_y_out_o,
  output logic                               to_memory_out_o,
  output logic                               broadcast_out_o,
  output logic [mrq_pkg::KindW-1:0]          kind_out_o,
  output logic [mrq_pkg::TagW-1:0]           tag_out_o,
  output logic [mrq_pkg::DelayW-1:0]         delay_out_o,
  output logic [mrq_pkg::CountW-1:0]         received_count_o
);
  import mrq_pkg::*;

  cfg_t       cfg_q;
  logic       cq_full, cq_empty, cq_push, cq_pop;
  cmd_t       cq_wdata, cq_rdata;
  result_t    res;
  back_stat_t bk_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.my_x          <= '0;
      cfg_q.my_y          <= '0;
      cfg_q.mesh_len      <= LenW'(8);
      cfg_q.queuing_delay <= CfgDelayW'(1);
      cfg_q.route_delay   <= CfgDelayW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMyX:        cfg_q.my_x          <= cfg_wdata_i[CoordW-1:0];
        CfgMyY:        cfg_q.my_y          <= cfg_wdata_i[CoordW-1:0];
        CfgMeshLen:    cfg_q.mesh_len      <= cfg_wdata_i[LenW-1:0];
        CfgQueuingDly: cfg_q.queuing_delay <= cfg_wdata_i[CfgDelayW-1:0];
        CfgRouteDly:   cfg_q.route_delay   <= cfg_wdata_i[CfgDelayW-1:0];
        default: ;
      endcase
    end
  end

  mrq_front u_front (
    .push_i            (push),
    .cmd_i             (cmd_i),
    .dest_x_i          (dest_x_i),
    .dest_y_i          (dest_y_i),
    .to_memory_i       (to_memory_i),
    .is_broadcast_i    (is_broadcast_i),
    .msg_kind_i        (msg_kind_i),
    .tag_in_i          (tag_in_i),
    .delay_in_i        (delay_in_i),
    .prefer_vertical_i (prefer_vertical_i),
    .route_delay_i     (cfg_q.route_delay),
    .cq_full_i         (cq_full),
    .full_o            (full),
    .cq_push_o         (cq_push),
    .cq_wdata_o        (cq_wdata)
  );

  mrq_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .wdata_i (cq_wdata),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .rdata_o (cq_rdata),
    .empty_o (cq_empty)
  );

  mrq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cq_empty),
    .cmd_i       (cq_rdata),
    .cmd_pop_o   (cq_pop),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .stat_o      (bk_stat)
  );

  assign action_o         = res.action;
  assign dest_x_out_o     = res.msg.dest_x;
  assign dest_y_out_o     = res.msg.dest_y;
  assign to_memory_out_o  = res.msg.to_mem;
  assign broadcast_out_o  = res.msg.bcast;
  assign kind_out_o       = res.msg.kind;
  assign tag_out_o        = res.msg.tag;
  assign delay_out_o      = res.delay;
  assign received_count_o = res.count;

  `MRQ_ASSERT_NEXT(a_accept_reaches_cmdq, clk_i, rst_ni, push && !full, !cq_empty, "accepted word missing from command queue")
  `MRQ_ASSERT_IMPLY(a_ptr_fill_agree, clk_i, rst_ni, bk_stat.head == bk_stat.tail, bk_stat.fill == '0 || bk_stat.fill == CntW'(QueueDepth), "store pointers disagree with fill count")
  `MRQ_ASSERT_IMPLY(a_no_msg_on_status, clk_i, rst_ni, !empty && (res.action == ACT_QUEUED || res.action == ACT_DROPPED || res.action == ACT_EMPTY), delay_out_o == '0 && tag_out_o == '0 && kind_out_o == '0, "status result carries message fields")

endmodule

`default_nettype wire

// ===== dv/tb_mesh_router_queue_route.sv =====
// Self-checking testbench for mesh_router_queue_route: random and directed command
// streams against an in-bench predictor of the message queue and route decision.
// Depends on mrq_pkg and the mesh_router_queue_route RTL only.
`timescale 1ns / 1ps

module tb_mesh_router_queue_route;
  import mrq_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned HoldOffCycles = 300;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 push;
  logic                 full;
  logic                 cmd_i;
  logic [CoordW-1:0]    dest_x_i;
  logic [CoordW-1:0]    dest_y_i;
  logic                 to_memory_i;
  logic                 is_broadcast_i;
  logic [KindW-1:0]     msg_kind_i;
  logic [TagW-1:0]      tag_in_i;
  logic [DelayW-1:0]    delay_in_i;
  logic                 prefer_vertical_i;
  logic                 empty;
  logic                 pop;
  logic [3:0]           action_o;
  logic [CoordW-1:0]    dest_x_out_o;
  logic [CoordW-1:0]    dest_y_out_o;
  logic                 to_memory_out_o;
  logic                 broadcast_out_o;
  logic [KindW-1:0]     kind_out_o;
  logic [TagW-1:0]      tag_out_o;
  logic [DelayW-1:0]    delay_out_o;
  logic [CountW-1:0]    received_count_o;

  mesh_router_queue_route i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push              (push),
    .full              (full),
    .cmd_i             (cmd_i),
    .dest_x_i          (dest_x_i),
    .dest_y_i          (dest_y_i),
    .to_memory_i       (to_memory_i),
    .is_broadcast_i    (is_broadcast_i),
    .msg_kind_i        (msg_kind_i),
    .tag_in_i          (tag_in_i),
    .delay_in_i        (delay_in_i),
    .prefer_vertical_i (prefer_vertical_i),
    .empty             (empty),
    .pop               (pop),
    .action_o          (action_o),
    .dest_x_out_o      (dest_x_out_o),
    .dest_y_out_o      (dest_y_out_o),
    .to_memory_out_o   (to_memory_out_o),
    .broadcast_out_o   (broadcast_out_o),
    .kind_out_o        (kind_out_o),
    .tag_out_o         (tag_out_o),
    .delay_out_o       (delay_out_o),
    .received_count_o  (received_count_o)
  );

  // Predictor state: configuration copy and message store.
  logic [CoordW-1:0]    my_x_cfg;
  logic [CoordW-1:0]    my_y_cfg;
  logic [LenW-1:0]      mesh_len_cfg;
  logic [CfgDelayW-1:0] queue_dly_cfg;
  logic [CfgDelayW-1:0] route_dly_cfg;
  msg_t                 stored_msg [QueueDepth];
  logic [DelayW-1:0]    stored_delay [QueueDepth];
  int unsigned          head_idx;
  int unsigned          tail_idx;
  int unsigned          stored_cnt;
  logic [CountW-1:0]    pkt_total;

  result_t     due_words [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned pop_hold_cycles;
  bit          send_idle;
  bit          recv_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [DelayW-1:0] add_clamped(logic [DelayW-1:0] a,
                                                    logic [DelayW-1:0] b);
    logic [DelayW:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[DelayW] ? '1 : total[DelayW-1:0];
  endfunction

  function automatic action_e memory_step();
    int len;
    int x;
    int y;
    len = int'(mesh_len_cfg);
    if (len > int'(MaxMesh)) len = MaxMesh;
    x = int'(my_x_cfg);
    y = int'(my_y_cfg);
    if (x == 0 || y == 0 || x >= len - 1 || y >= len - 1) return ACT_MEMORY;
    // head for the nearest mesh edge
    if (((x < len - x) ? x : len - x) < ((y < len - y) ? y : len - y))
      return (x < len - x) ? ACT_WEST : ACT_EAST;
    return (y < len - y) ? ACT_NORTH : ACT_SOUTH;
  endfunction

  function automatic action_e tile_step(msg_t m, logic vert);
    int x;
    int y;
    int dx;
    int dy;
    x  = int'(my_x_cfg);
    y  = int'(my_y_cfg);
    dx = int'(m.dest_x);
    dy = int'(m.dest_y);
    if (vert ? (dy != y) : (dx == x)) return (dy > y) ? ACT_SOUTH : ACT_NORTH;
    return (dx > x) ? ACT_EAST : ACT_WEST;
  endfunction

  function automatic result_t advance_router(cmd_t c);
    result_t     r;
    msg_t        m;
    int unsigned p;
    int unsigned i;
    r = '0;
    if (!c.dispatch) begin
      if (stored_cnt >= QueueDepth) begin
        r.action = ACT_DROPPED;
      end else begin
        stored_msg[tail_idx]   = c.msg;
        stored_delay[tail_idx] = add_clamped(c.delay, DelayW'(route_dly_cfg));
        tail_idx   = (tail_idx + 1) % QueueDepth;
        stored_cnt = stored_cnt + 1;
        pkt_total  = pkt_total + 1'b1;
        r.action   = ACT_QUEUED;
      end
    end else if (stored_cnt == 0) begin
      r.action = ACT_EMPTY;
    end else begin
      // age every waiting word, head included, before the pop
      p = head_idx;
      for (i = 0; i < stored_cnt; i++) begin
        stored_delay[p] = add_clamped(stored_delay[p], DelayW'(queue_dly_cfg));
        p = (p + 1) % QueueDepth;
      end
      m       = stored_msg[head_idx];
      r.msg   = m;
      r.delay = stored_delay[head_idx];
      head_idx   = (head_idx + 1) % QueueDepth;
      stored_cnt = stored_cnt - 1;
      if ((m.dest_x == my_x_cfg && m.dest_y == my_y_cfg) || m.bcast)
        r.action = (m.kind <= 2'd1) ? ACT_LOCAL : ACT_BADKIND;
      else if (m.to_mem)
        r.action = memory_step();
      else
        r.action = tile_step(m, c.prefer_vert);
    end
    r.count = pkt_total;
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic disp, logic [CoordW-1:0] dx,
                                    logic [CoordW-1:0] dy, logic mem, logic bc,
                                    logic [KindW-1:0] kind, logic [TagW-1:0] tag,
                                    logic [DelayW-1:0] dly, logic vert);
    cmd_t c;
    c.dispatch    = disp;
    c.prefer_vert = vert;
    c.msg.dest_x  = dx;
    c.msg.dest_y  = dy;
    c.msg.to_mem  = mem;
    c.msg.bcast   = bc;
    c.msg.kind    = kind;
    c.msg.tag     = tag;
    c.delay       = dly;
    return c;
  endfunction

  function automatic cmd_t random_command(int unsigned dispatch_pct);
    cmd_t        c;
    int unsigned pick;
    int unsigned span;
    c.dispatch    = ($urandom_range(0, 99) < dispatch_pct);
    c.prefer_vert = 1'($urandom_range(0, 1));
    span = (mesh_len_cfg > MaxMesh) ? MaxMesh : int'(mesh_len_cfg);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      c.msg.dest_x = my_x_cfg;
      c.msg.dest_y = my_y_cfg;
    end else if (pick == 1) begin
      c.msg.dest_x = my_x_cfg;
      c.msg.dest_y = CoordW'($urandom_range(0, span - 1));
    end else if (pick < 6) begin
      c.msg.dest_x = CoordW'($urandom_range(0, span - 1));
      c.msg.dest_y = CoordW'($urandom_range(0, span - 1));
    end else begin
      c.msg.dest_x = CoordW'($urandom);
      c.msg.dest_y = CoordW'($urandom);
    end
    c.msg.to_mem = ($urandom_range(0, 3) == 0);
    c.msg.bcast  = ($urandom_range(0, 7) == 0);
    c.msg.kind   = ($urandom_range(0, 7) == 0) ? KindW'($urandom_range(2, 3))
                                               : KindW'($urandom_range(0, 1));
    c.msg.tag    = TagW'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0)
      c.delay = '0;
    else if (pick < 3)
      c.delay = 32'hFFFF_FFFF - $urandom_range(0, 300000);
    else
      c.delay = $urandom;
    return c;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(cmd_t c);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push              = 1'b1;
    cmd_i             = c.dispatch;
    dest_x_i          = c.msg.dest_x;
    dest_y_i          = c.msg.dest_y;
    to_memory_i       = c.msg.to_mem;
    is_broadcast_i    = c.msg.bcast;
    msg_kind_i        = c.msg.kind;
    tag_in_i          = c.msg.tag;
    delay_in_i        = c.delay;
    prefer_vertical_i = c.prefer_vert;
    do @(posedge clk_i); while (full);
    due_words.insert(due_words.size(), advance_router(c));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                               logic [LenW-1:0] len, logic [CfgDelayW-1:0] qd,
                               logic [CfgDelayW-1:0] rd);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CfgMyX;
    cfg_wdata_i = CfgDataW'(x);
    @(negedge clk_i);
    cfg_idx_i   = CfgMyY;
    cfg_wdata_i = CfgDataW'(y);
    @(negedge clk_i);
    cfg_idx_i   = CfgMeshLen;
    cfg_wdata_i = CfgDataW'(len);
    @(negedge clk_i);
    cfg_idx_i   = CfgQueuingDly;
    cfg_wdata_i = qd;
    @(negedge clk_i);
    cfg_idx_i   = CfgRouteDly;
    cfg_wdata_i = rd;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    my_x_cfg      = x;
    my_y_cfg      = y;
    mesh_len_cfg  = len;
    queue_dly_cfg = qd;
    route_dly_cfg = rd;
  endtask

  // Defaults after reset: tile (0,0), empty pop, saturation, local and bad kinds.
  task automatic test_reset_defaults();
    int i;
    send_item(make_cmd(1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 2'd0, 16'h0000, 32'h0, 1'b0));
    send_item(make_cmd(1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 2'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    send_item(make_cmd(1'b0, 6'd63, 6'd63, 1'b1, 1'b1, 2'd3, 16'h0000, 32'h0, 1'b0));
    send_item(make_cmd(1'b0, 6'd0, 6'd0, 1'b0, 1'b0, 2'd2, 16'h5A5A, 32'hFFFF_FFFE, 1'b0));
    send_item(make_cmd(1'b0, 6'd5, 6'd5, 1'b1, 1'b0, 2'd1, 16'hA5A5, 32'd1234, 1'b0));
    send_item(make_cmd(1'b0, 6'd7, 6'd2, 1'b0, 1'b0, 2'd1, 16'h1234, 32'h8000_0000, 1'b1));
    for (i = 0; i < 6; i++)
      send_item(make_cmd(1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 2'd0, 16'h0, 32'h0, i[0]));
  endtask

  // One enqueue and one dispatch per case, from an interior tile.
  task automatic test_route_directions();
    logic [CoordW-1:0] dxs [7];
    logic [CoordW-1:0] dys [7];
    logic              verts [7];
    int                i;
    dxs   = '{6'd6, 6'd0, 6'd3, 6'd3, 6'd6, 6'd6, 6'd1};
    dys   = '{6'd5, 6'd5, 6'd7, 6'd0, 6'd1, 6'd1, 6'd1};
    verts = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    apply_setting(6'd3, 6'd5, 7'd8, 16'd7, 16'd3);
    for (i = 0; i < 7; i++) begin
      // last case is memory-bound
      send_item(make_cmd(1'b0, dxs[i], dys[i], i == 6, 1'b0, 2'(i % 2), 16'(i), 32'(i), 1'b0));
      send_item(make_cmd(1'b1, 6'd0, 6'd0, 1'b0, 1'b0, 2'd0, 16'h0, 32'h0, verts[i]));
    end
  endtask

  // Overfill the store so enqueues drop, then drain past empty.
  task automatic test_queue_overflow();
    int i;
    apply_setting(CoordW'($urandom), CoordW'($urandom), LenW'($urandom_range(2, 64)),
                  CfgDelayW'($urandom), CfgDelayW'($urandom));
    for (i = 0; i < 20; i++) send_item(random_command(0));
    for (i = 0; i < 18; i++) send_item(random_command(100));
  endtask

  // Hold the result side off so the block fills and stalls its input.
  task automatic test_input_backpressure();
    int i;
    wait_drained();
    send_idle       = 1'b0;
    pop_hold_cycles = HoldOffCycles;
    for (i = 0; i < 40; i++) send_item(random_command(25));
    send_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          s;
    int          i;
    int unsigned len;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CfgDelayW-1:0] qd;
    logic [CfgDelayW-1:0] rd;
    for (s = 0; s < 6; s++) begin
      if (s == 0) begin
        apply_setting(6'd0, 6'd0, 7'd2, 16'd0, 16'd0);
      end else if (s == 1) begin
        apply_setting(6'd63, 6'd63, 7'd64, 16'hFFFF, 16'hFFFF);
      end else begin
        len = $urandom_range(4, 64);
        x = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, len - 2));
        y = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, len - 2));
        qd = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        rd = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        apply_setting(x, y, 7'(len), qd, rd);
      end
      // one stretch runs flat out on both sides
      send_idle = (s == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_idle = (s == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (i = 0; i < 130; i++) send_item(random_command(35 + 10 * (s % 4)));
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    int i;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgMyX;
    cfg_wdata_i       = '0;
    push              = 1'b0;
    cmd_i             = 1'b0;
    dest_x_i          = '0;
    dest_y_i          = '0;
    to_memory_i       = 1'b0;
    is_broadcast_i    = 1'b0;
    msg_kind_i        = '0;
    tag_in_i          = '0;
    delay_in_i        = '0;
    prefer_vertical_i = 1'b0;
    mismatches        = 0;
    pop_hold_cycles   = 0;
    send_idle         = 1'b1;
    recv_idle         = 1'b1;
    my_x_cfg          = '0;
    my_y_cfg          = '0;
    mesh_len_cfg      = 7'd8;
    queue_dly_cfg     = 16'd1;
    route_dly_cfg     = 16'd1;
    head_idx          = 0;
    tail_idx          = 0;
    stored_cnt        = 0;
    pkt_total         = '0;
    for (i = 0; i < QueueDepth; i++) begin
      stored_msg[i]   = '0;
      stored_delay[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_route_directions();
    test_queue_overflow();
    test_input_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("PASS mesh_router_queue_route");
    end else begin
      $display("FAIL mesh_router_queue_route");
    end
    $finish;
  end

  // Result side: random pop gaps, hold-off on request, compare each word.
  initial begin : result_checker
    result_t     want;
    int unsigned gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (pop_hold_cycles != 0) begin
        repeat (pop_hold_cycles) begin
          @(negedge clk_i);
          pop = 1'b0;
        end
        pop_hold_cycles = 0;
      end
      gap = recv_idle ? $urandom_range(0, 16) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        pop = 1'b0;
      end
      @(negedge clk_i);
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      if (due_words.size() == 0) begin
        $error("result word with nothing expected: action %0d", action_o);
        mismatches++;
      end else begin
        want = due_words[0];
        due_words.delete(0);
        check_field("action", 32'(want.action), 32'(action_o));
        check_field("dest_x_out", 32'(want.msg.dest_x), 32'(dest_x_out_o));
        check_field("dest_y_out", 32'(want.msg.dest_y), 32'(dest_y_out_o));
        check_field("to_memory_out", 32'(want.msg.to_mem), 32'(to_memory_out_o));
        check_field("broadcast_out", 32'(want.msg.bcast), 32'(broadcast_out_o));
        check_field("kind_out", 32'(want.msg.kind), 32'(kind_out_o));
        check_field("tag_out", 32'(want.msg.tag), 32'(tag_out_o));
        check_field("delay_out", want.delay, delay_out_o);
        check_field("received_count", want.count, received_count_o);
      end
    end
  end

  // Abort when no word moves on either side for too long.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL mesh_router_queue_route");
      $finish;
    end
  end

endmodule
